// ----- sv/ssp_pkg.sv -----
package ssp_pkg;

	localparam int Nodes      = 1024;
	localparam int Edges      = 4096;
	localparam int NodeW      = $clog2(Nodes);
	localparam int EntryDepth = 2 * Edges;
	localparam int EntryW     = $clog2(EntryDepth);
	localparam int UsedW      = $clog2(EntryDepth + 1);
	localparam int HeapDepth  = EntryDepth + 1;
	localparam int HeapW      = $clog2(HeapDepth + 1);
	localparam int DistW      = 18;
	localparam int WeightW    = 8;

	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_RUN   = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NO_SOURCE = 2'd2;

	typedef struct packed {
		logic [1:0]         command;
		logic [9:0]         node_a;
		logic [9:0]         node_b;
		logic [WeightW-1:0] weight;
	} request_t;

	typedef struct packed {
		logic [1:0]       status;
		logic             reachable;
		logic [DistW-1:0] distance;
		logic [9:0]       predecessor;
		logic             has_predecessor;
	} response_t;

	typedef struct packed {
		logic              present;
		logic [EntryW-1:0] head;
		logic [EntryW-1:0] tail;
	} node_t;

	typedef struct packed {
		logic             reached;
		logic [DistW-1:0] path_len;
		logic             pvalid;
		logic [NodeW-1:0] pred;
	} res_t;

	typedef struct packed {
		logic [NodeW-1:0]   to;
		logic [WeightW-1:0] w;
		logic [EntryW-1:0]  next;
	} adj_t;

	typedef struct packed {
		logic [DistW-1:0] d;
		logic [NodeW-1:0] n;
	} hent_t;

	typedef struct packed {
		logic  push;
		logic  pop;
		logic  clr;
		hent_t key;
	} heap_req_t;

	typedef struct packed {
		logic  busy;
		logic  empty;
		hent_t top;
	} heap_sts_t;

	function automatic logic hent_less(hent_t a, hent_t b);
		return (a.d < b.d) || ((a.d == b.d) && (a.n < b.n));
	endfunction

	function automatic response_t status_only(logic [1:0] s);
		response_t r;
		r = '0;
		r.status = s;
		return r;
	endfunction

endpackage

// ----- sv/ssp_ram.sv -----
module ssp_ram #(
	parameter int Width = 8,
	parameter int Depth = 16,
	localparam int AddrW = $clog2(Depth)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- sv/ssp_heap.sv -----
module ssp_heap (
	input  logic               clk,
	input  logic               arst_n,
	input  ssp_pkg::heap_req_t req,
	output ssp_pkg::heap_sts_t sts
);

	typedef enum logic [8:0] {
		H_IDLE     = 9'b000000001,
		H_POP_TOP  = 9'b000000010,
		H_POP_LAST = 9'b000000100,
		H_SD_L     = 9'b000001000,
		H_SD_R     = 9'b000010000,
		H_SD_C     = 9'b000100000,
		H_PU_RD    = 9'b001000000,
		H_PU_C     = 9'b010000000,
		H_PU_WR    = 9'b100000000
	} hstate_t;

	hstate_t                      state_q;
	logic [ssp_pkg::HeapW-1:0]    cnt_q;
	logic [ssp_pkg::HeapW-1:0]    pos_q;
	ssp_pkg::hent_t               x_q;
	ssp_pkg::hent_t               top_q;
	ssp_pkg::hent_t               hl_q;
	logic                         hasr_q;

	logic                         we;
	logic [ssp_pkg::HeapW-1:0]    waddr;
	ssp_pkg::hent_t               wdata;
	logic [ssp_pkg::HeapW-1:0]    raddr;
	ssp_pkg::hent_t               rdata;

	logic [ssp_pkg::HeapW:0]      lidx;
	logic [ssp_pkg::HeapW:0]      ridx;
	logic [ssp_pkg::HeapW-1:0]    parent;
	logic                         l_in;
	logic                         lt_l;
	logic                         lt_r;
	ssp_pkg::hent_t               bv;
	logic                         up;

	always_comb begin
		lidx   = {pos_q, 1'b1};
		ridx   = lidx + 1'b1;
		parent = (pos_q - 1'b1) >> 1;
		l_in   = lidx < {1'b0, cnt_q};
		lt_l   = ssp_pkg::hent_less(hl_q, x_q);
		bv     = lt_l ? hl_q : x_q;
		lt_r   = hasr_q && ssp_pkg::hent_less(rdata, bv);
		up     = ssp_pkg::hent_less(x_q, rdata);
	end

	always_comb begin
		we    = 1'b0;
		waddr = pos_q;
		wdata = x_q;
		raddr = '0;
		unique case (state_q)
			H_IDLE:     raddr = '0;
			H_POP_TOP:  raddr = cnt_q;
			H_POP_LAST: raddr = '0;
			H_SD_L: begin
				if (l_in) begin
					raddr = lidx[ssp_pkg::HeapW-1:0];
				end else begin
					we = 1'b1;
				end
			end
			H_SD_R:     raddr = ridx[ssp_pkg::HeapW-1:0];
			H_SD_C: begin
				we = 1'b1;
				if (lt_r) begin
					wdata = rdata;
				end else if (lt_l) begin
					wdata = hl_q;
				end
			end
			H_PU_RD:    raddr = parent;
			H_PU_C: begin
				we = 1'b1;
				if (up) begin
					wdata = rdata;
				end
			end
			H_PU_WR:    we = 1'b1;
			default:    we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				H_IDLE: begin
					if (req.clr) begin
						cnt_q <= '0;
					end else if (req.pop && (cnt_q != '0)) begin
						cnt_q   <= cnt_q - 1'b1;
						state_q <= H_POP_TOP;
					end else if (req.push &&
					             (cnt_q != ssp_pkg::HeapW'(ssp_pkg::HeapDepth))) begin
						pos_q   <= cnt_q;
						cnt_q   <= cnt_q + 1'b1;
						x_q     <= req.key;
						state_q <= (cnt_q == '0) ? H_PU_WR : H_PU_RD;
					end
				end
				H_POP_TOP: begin
					top_q   <= rdata;
					state_q <= H_POP_LAST;
				end
				H_POP_LAST: begin
					x_q     <= rdata;
					pos_q   <= '0;
					state_q <= (cnt_q == '0) ? H_IDLE : H_SD_L;
				end
				H_SD_L:     state_q <= l_in ? H_SD_R : H_IDLE;
				H_SD_R: begin
					hl_q    <= rdata;
					hasr_q  <= ridx < {1'b0, cnt_q};
					state_q <= H_SD_C;
				end
				H_SD_C: begin
					if (lt_r) begin
						pos_q   <= ridx[ssp_pkg::HeapW-1:0];
						state_q <= H_SD_L;
					end else if (lt_l) begin
						pos_q   <= lidx[ssp_pkg::HeapW-1:0];
						state_q <= H_SD_L;
					end else begin
						state_q <= H_IDLE;
					end
				end
				H_PU_RD:    state_q <= H_PU_C;
				H_PU_C: begin
					if (up) begin
						pos_q   <= parent;
						state_q <= (parent == '0) ? H_PU_WR : H_PU_RD;
					end else begin
						state_q <= H_IDLE;
					end
				end
				H_PU_WR:    state_q <= H_IDLE;
				default:    state_q <= H_IDLE;
			endcase
		end
	end

	ssp_ram #(
		.Width($bits(ssp_pkg::hent_t)),
		.Depth(ssp_pkg::HeapDepth)
	) u_heap_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign sts.busy  = state_q != H_IDLE;
	assign sts.empty = cnt_q == '0;
	assign sts.top   = top_q;

endmodule

// ----- sv/single_source_shortest_path_unit.sv -----
// channel   | ports                    | handshake
// ----------+--------------------------+------------------------------------
// command   | start, busy, request     | taken when start high and busy low
// result    | done, response           | one cycle with done, cannot stall
//
// an add on a full store returns status full without raising busy
// run: a wipe of the result memory, then for each popped entry a sift of the
// heap and, unless the entry is stale, a walk over its node's edges; a push
// overlaps the edge walk and stalls it only while the heap is still busy
// after reset a wipe of all 1024 node and result memory entries holds busy high
module single_source_shortest_path_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  ssp_pkg::request_t  request,
	output logic               done,
	output ssp_pkg::response_t response
);

	typedef enum logic [15:0] {
		S_IDLE     = 16'h0001,
		S_WIPE     = 16'h0002,
		S_ADD_RD   = 16'h0004,
		S_ADD_WR   = 16'h0008,
		S_ADD_LINK = 16'h0010,
		S_QRY_RD   = 16'h0020,
		S_QRY_OUT  = 16'h0040,
		S_RUN_RD   = 16'h0080,
		S_RUN_SRC  = 16'h0100,
		S_POP      = 16'h0200,
		S_POP_WAIT = 16'h0400,
		S_VISIT_RD = 16'h0800,
		S_VISIT    = 16'h1000,
		S_EDGE_RD  = 16'h2000,
		S_EDGE     = 16'h4000,
		S_RELAX    = 16'h8000
	} state_t;

	state_t                           state_q;
	ssp_pkg::request_t                req_q;
	logic                             report_q;
	logic                             wipe_node_q;
	logic [ssp_pkg::NodeW-1:0]        wipe_q;
	logic [ssp_pkg::UsedW-1:0]        used_q;
	logic                             side_q;
	logic [ssp_pkg::EntryW-1:0]       new_q;
	logic [ssp_pkg::EntryW-1:0]       link_q;
	logic [ssp_pkg::NodeW-1:0]        u_q;
	logic [ssp_pkg::DistW-1:0]        d_q;
	logic [ssp_pkg::EntryW-1:0]       e_q;
	logic [ssp_pkg::EntryW-1:0]       tail_q;
	logic [ssp_pkg::EntryW-1:0]       next_q;
	logic [ssp_pkg::NodeW-1:0]        v_q;
	logic [ssp_pkg::DistW-1:0]        nd_q;
	logic                             done_q;
	ssp_pkg::response_t               resp_q;

	logic                             n_we;
	logic [ssp_pkg::NodeW-1:0]        n_waddr;
	ssp_pkg::node_t                   n_wdata;
	logic [ssp_pkg::NodeW-1:0]        n_raddr;
	ssp_pkg::node_t                   n_rdata;
	logic                             r_we;
	logic [ssp_pkg::NodeW-1:0]        r_waddr;
	ssp_pkg::res_t                    r_wdata;
	logic [ssp_pkg::NodeW-1:0]        r_raddr;
	ssp_pkg::res_t                    r_rdata;
	logic                             a_we;
	logic [ssp_pkg::EntryW-1:0]       a_waddr;
	ssp_pkg::adj_t                    a_wdata;
	logic [ssp_pkg::EntryW-1:0]       a_raddr;
	ssp_pkg::adj_t                    a_rdata;
	ssp_pkg::heap_req_t               hreq;
	ssp_pkg::heap_sts_t               hsts;

	logic [ssp_pkg::NodeW-1:0]        node_a;
	logic [ssp_pkg::NodeW-1:0]        node_b;
	logic [ssp_pkg::NodeW-1:0]        cur_node;
	logic [ssp_pkg::NodeW-1:0]        far_node;
	logic [ssp_pkg::EntryW-1:0]       idx;
	logic                             improve;
	logic                             skip;
	logic                             full;
	logic                             finish;
	ssp_pkg::response_t               fin_resp;

	always_comb begin
		node_a   = req_q.node_a[ssp_pkg::NodeW-1:0];
		node_b   = req_q.node_b[ssp_pkg::NodeW-1:0];
		cur_node = side_q ? node_b : node_a;
		far_node = side_q ? node_a : node_b;
		idx      = used_q[ssp_pkg::EntryW-1:0];
		full     = used_q > ssp_pkg::UsedW'(ssp_pkg::EntryDepth - 2);
		// an unreached node counts as infinitely far
		improve  = !r_rdata.reached || (nd_q < r_rdata.path_len);
		skip     = !n_rdata.present || (r_rdata.reached && (d_q > r_rdata.path_len));
	end

	// result of the item that ends in this cycle
	always_comb begin
		finish   = 1'b0;
		fin_resp = ssp_pkg::status_only(ssp_pkg::ST_OK);
		unique case (state_q)
			S_IDLE: begin
				if (start && (request.command == ssp_pkg::CMD_ADD) && full) begin
					finish   = 1'b1;
					fin_resp = ssp_pkg::status_only(ssp_pkg::ST_FULL);
				end
			end
			S_WIPE: begin
				finish = (wipe_q == ssp_pkg::NodeW'(ssp_pkg::Nodes - 1)) && report_q &&
				         (req_q.command != ssp_pkg::CMD_RUN);
			end
			S_ADD_WR:   finish = !n_rdata.present && side_q;
			S_ADD_LINK: finish = side_q;
			S_QRY_OUT: begin
				finish = 1'b1;
				if (n_rdata.present && r_rdata.reached) begin
					fin_resp.reachable       = 1'b1;
					fin_resp.distance        = r_rdata.path_len;
					fin_resp.has_predecessor = r_rdata.pvalid;
					fin_resp.predecessor     = r_rdata.pvalid ? 10'(r_rdata.pred) : 10'd0;
				end
			end
			S_RUN_SRC: begin
				if (!n_rdata.present) begin
					finish   = 1'b1;
					fin_resp = ssp_pkg::status_only(ssp_pkg::ST_NO_SOURCE);
				end
			end
			S_POP:      finish = !hsts.busy && hsts.empty;
			default: ;
		endcase
	end

	always_comb begin
		n_we     = 1'b0;
		n_waddr  = cur_node;
		n_wdata  = '0;
		n_raddr  = cur_node;
		r_we     = 1'b0;
		r_waddr  = v_q;
		r_wdata  = '0;
		r_raddr  = v_q;
		a_we     = 1'b0;
		a_waddr  = idx;
		a_wdata  = '0;
		a_raddr  = e_q;
		hreq     = '0;
		unique case (state_q)
			S_IDLE: ;
			S_WIPE: begin
				n_we    = wipe_node_q;
				n_waddr = wipe_q;
				r_we    = 1'b1;
				r_waddr = wipe_q;
			end
			S_ADD_RD: ;
			S_ADD_WR: begin
				a_we          = 1'b1;
				a_wdata.to    = far_node;
				a_wdata.w     = req_q.weight;
				n_we          = 1'b1;
				n_wdata.present = 1'b1;
				n_wdata.head  = n_rdata.present ? n_rdata.head : idx;
				n_wdata.tail  = idx;
				a_raddr       = n_rdata.tail;
			end
			S_ADD_LINK: begin
				a_we    = 1'b1;
				a_waddr = link_q;
				a_wdata = '{to: a_rdata.to, w: a_rdata.w, next: new_q};
			end
			S_QRY_RD, S_QRY_OUT: begin
				n_raddr = node_a;
				r_raddr = node_a;
			end
			S_RUN_RD: begin
				n_raddr  = node_a;
				hreq.clr = 1'b1;
			end
			S_RUN_SRC: begin
				n_raddr = node_a;
				if (n_rdata.present) begin
					r_we           = 1'b1;
					r_waddr        = node_a;
					r_wdata.reached = 1'b1;
					hreq.push      = 1'b1;
					hreq.key       = '{d: '0, n: node_a};
				end
			end
			S_POP:      hreq.pop = !hsts.busy && !hsts.empty;
			S_POP_WAIT: ;
			S_VISIT_RD, S_VISIT: begin
				n_raddr = u_q;
				r_raddr = u_q;
			end
			S_EDGE_RD:  ;
			S_EDGE:     r_raddr = a_rdata.to;
			S_RELAX: begin
				if (improve && !hsts.busy) begin
					r_we      = 1'b1;
					r_wdata   = '{reached: 1'b1, path_len: nd_q, pvalid: 1'b1, pred: u_q};
					hreq.push = 1'b1;
					hreq.key  = '{d: nd_q, n: v_q};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_WIPE;
			report_q    <= 1'b0;
			wipe_node_q <= 1'b1;
			wipe_q      <= '0;
			used_q      <= '0;
			side_q      <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q <= finish;
			if (finish) begin
				resp_q <= fin_resp;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q    <= request;
						report_q <= 1'b1;
						side_q   <= 1'b0;
						wipe_q   <= '0;
						unique case (request.command)
							ssp_pkg::CMD_ADD: begin
								if (!full) begin
									state_q <= S_ADD_RD;
								end
							end
							ssp_pkg::CMD_RUN: begin
								wipe_node_q <= 1'b0;
								state_q     <= S_WIPE;
							end
							ssp_pkg::CMD_QUERY: state_q <= S_QRY_RD;
							ssp_pkg::CMD_CLEAR: begin
								wipe_node_q <= 1'b1;
								used_q      <= '0;
								state_q     <= S_WIPE;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_WIPE: begin
					wipe_q <= wipe_q + 1'b1;
					if (wipe_q == ssp_pkg::NodeW'(ssp_pkg::Nodes - 1)) begin
						if (report_q && (req_q.command == ssp_pkg::CMD_RUN)) begin
							state_q <= S_RUN_RD;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_ADD_RD:   state_q <= S_ADD_WR;
				S_ADD_WR: begin
					used_q <= used_q + 1'b1;
					new_q  <= idx;
					link_q <= n_rdata.tail;
					if (n_rdata.present) begin
						state_q <= S_ADD_LINK;
					end else if (!side_q) begin
						side_q  <= 1'b1;
						state_q <= S_ADD_RD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_ADD_LINK: begin
					if (!side_q) begin
						side_q  <= 1'b1;
						state_q <= S_ADD_RD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_QRY_RD:   state_q <= S_QRY_OUT;
				S_QRY_OUT:  state_q <= S_IDLE;
				S_RUN_RD:   state_q <= S_RUN_SRC;
				S_RUN_SRC: begin
					if (n_rdata.present) begin
						state_q <= S_POP;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_POP: begin
					if (!hsts.busy) begin
						if (hsts.empty) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_POP_WAIT;
						end
					end
				end
				S_POP_WAIT: begin
					if (!hsts.busy) begin
						u_q     <= hsts.top.n;
						d_q     <= hsts.top.d;
						state_q <= S_VISIT_RD;
					end
				end
				S_VISIT_RD: state_q <= S_VISIT;
				S_VISIT: begin
					// stale heap entries are dropped here
					if (skip) begin
						state_q <= S_POP;
					end else begin
						e_q     <= n_rdata.head;
						tail_q  <= n_rdata.tail;
						state_q <= S_EDGE_RD;
					end
				end
				S_EDGE_RD:  state_q <= S_EDGE;
				S_EDGE: begin
					v_q     <= a_rdata.to;
					nd_q    <= d_q + ssp_pkg::DistW'(a_rdata.w);
					next_q  <= a_rdata.next;
					state_q <= S_RELAX;
				end
				S_RELAX: begin
					// wait for the heap only when a push is due
					if (!improve || !hsts.busy) begin
						if (e_q == tail_q) begin
							state_q <= S_POP;
						end else begin
							e_q     <= next_q;
							state_q <= S_EDGE_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	ssp_ram #(
		.Width($bits(ssp_pkg::node_t)),
		.Depth(ssp_pkg::Nodes)
	) u_node_ram (
		.clk  (clk),
		.we   (n_we),
		.waddr(n_waddr),
		.wdata(n_wdata),
		.raddr(n_raddr),
		.rdata(n_rdata)
	);

	ssp_ram #(
		.Width($bits(ssp_pkg::res_t)),
		.Depth(ssp_pkg::Nodes)
	) u_res_ram (
		.clk  (clk),
		.we   (r_we),
		.waddr(r_waddr),
		.wdata(r_wdata),
		.raddr(r_raddr),
		.rdata(r_rdata)
	);

	ssp_ram #(
		.Width($bits(ssp_pkg::adj_t)),
		.Depth(ssp_pkg::EntryDepth)
	) u_adj_ram (
		.clk  (clk),
		.we   (a_we),
		.waddr(a_waddr),
		.wdata(a_wdata),
		.raddr(a_raddr),
		.rdata(a_rdata)
	);

	ssp_heap u_heap (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (hreq),
		.sts   (hsts)
	);

	assign busy     = state_q != S_IDLE;
	assign done     = done_q;
	assign response = resp_q;

endmodule

// ----- sv/ssp_checker.sv -----
module ssp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input ssp_pkg::request_t  request,
	input logic               done,
	input ssp_pkg::response_t response
);

	// an accepted item either keeps the block busy or is answered at once
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted item neither raised busy nor gave a result");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (response.status == ssp_pkg::ST_OK) ||
		         (response.status == ssp_pkg::ST_FULL) ||
		         (response.status == ssp_pkg::ST_NO_SOURCE))
		else $error("unknown status code");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && (response.status != ssp_pkg::ST_OK) |->
		!response.reachable && !response.has_predecessor && (response.distance == '0))
		else $error("error result carries query fields");

	a_pred_reach: assert property (@(posedge clk) disable iff (!arst_n)
		done && response.has_predecessor |-> response.reachable)
		else $error("predecessor on unreached node");

endmodule

bind single_source_shortest_path_unit ssp_checker u_ssp_checker (.*);

// ----- tb/tb_single_source_shortest_path_unit.sv -----
module tb_single_source_shortest_path_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          CycleLimit = 6000000;
	localparam int unsigned DistInf    = 32'hFFFF_FFFF;

	logic               clk    = 1'b0;
	logic               arst_n = 1'b0;
	logic               start  = 1'b0;
	logic               busy;
	ssp_pkg::request_t  request = '0;
	logic               done;
	ssp_pkg::response_t response;

	single_source_shortest_path_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.request  (request),
		.done     (done),
		.response (response)
	);

	always #10 clk = ~clk;

	// own copy of the graph and of the last run
	bit          present [ssp_pkg::Nodes];
	int unsigned head [ssp_pkg::Nodes], tail [ssp_pkg::Nodes];
	int unsigned adj_to [ssp_pkg::EntryDepth], adj_w [ssp_pkg::EntryDepth];
	int unsigned adj_next [ssp_pkg::EntryDepth];
	int unsigned used;
	int unsigned best [ssp_pkg::Nodes], back [ssp_pkg::Nodes];
	bit          back_ok [ssp_pkg::Nodes];
	int unsigned heap_d [ssp_pkg::HeapDepth], heap_n [ssp_pkg::HeapDepth];
	int unsigned heap_cnt;

	ssp_pkg::request_t  pending [$];
	ssp_pkg::response_t awaited [$];
	int        idle_pct = 0;
	int        mismatches = 0;
	int        cycles = 0;
	int        n_cmd [4];
	int        n_full = 0, n_nosrc = 0, n_reached = 0;
	int        pool [16];

	function automatic bit key_less(int unsigned d1, int unsigned n1, int unsigned d2,
		int unsigned n2);
		return (d1 < d2) || ((d1 == d2) && (n1 < n2));
	endfunction

	function automatic void wipe_paths();
		for (int i = 0; i < ssp_pkg::Nodes; i++) begin
			best[i] = DistInf;
			back[i] = 0;
			back_ok[i] = 1'b0;
		end
	endfunction

	function automatic void wipe_graph();
		for (int i = 0; i < ssp_pkg::Nodes; i++) present[i] = 1'b0;
		used = 0;
		heap_cnt = 0;
		wipe_paths();
	endfunction

	function automatic void frontier_push(int unsigned d, int unsigned n);
		int unsigned i, p, t;
		if (heap_cnt >= ssp_pkg::HeapDepth) return;
		i = heap_cnt;
		heap_cnt++;
		heap_d[i] = d;
		heap_n[i] = n;
		while (i > 0) begin
			p = (i - 1) / 2;
			if (!key_less(heap_d[i], heap_n[i], heap_d[p], heap_n[p])) break;
			t = heap_d[i]; heap_d[i] = heap_d[p]; heap_d[p] = t;
			t = heap_n[i]; heap_n[i] = heap_n[p]; heap_n[p] = t;
			i = p;
		end
	endfunction

	function automatic void frontier_pop(output int unsigned d, output int unsigned n);
		int unsigned i, l, r, m, t;
		d = heap_d[0];
		n = heap_n[0];
		heap_cnt--;
		heap_d[0] = heap_d[heap_cnt];
		heap_n[0] = heap_n[heap_cnt];
		i = 0;
		forever begin
			l = 2 * i + 1;
			r = l + 1;
			m = i;
			if (l < heap_cnt && key_less(heap_d[l], heap_n[l], heap_d[m], heap_n[m])) m = l;
			if (r < heap_cnt && key_less(heap_d[r], heap_n[r], heap_d[m], heap_n[m])) m = r;
			if (m == i) break;
			t = heap_d[i]; heap_d[i] = heap_d[m]; heap_d[m] = t;
			t = heap_n[i]; heap_n[i] = heap_n[m]; heap_n[m] = t;
			i = m;
		end
	endfunction

	function automatic void link_entry(int unsigned node, int unsigned dst, int unsigned w);
		int unsigned idx;
		idx = used;
		used++;
		adj_to[idx] = dst;
		adj_w[idx] = w;
		adj_next[idx] = 0;
		if (present[node]) begin
			adj_next[tail[node]] = idx;
		end else begin
			head[node] = idx;
			present[node] = 1'b1;
		end
		tail[node] = idx;
	endfunction

	function automatic logic [1:0] shortest_paths(int unsigned src);
		int unsigned d, u, e, v, nd;
		wipe_paths();
		heap_cnt = 0;
		if (!present[src]) return ssp_pkg::ST_NO_SOURCE;
		best[src] = 0;
		frontier_push(0, src);
		while (heap_cnt > 0) begin
			frontier_pop(d, u);
			if (d > best[u] || !present[u]) continue;
			e = head[u];
			forever begin
				v = adj_to[e];
				nd = d + adj_w[e];
				if (nd < best[v]) begin
					best[v] = nd;
					back[v] = u;
					back_ok[v] = 1'b1;
					frontier_push(nd, v);
				end
				if (e == tail[u]) break;
				e = adj_next[e];
			end
		end
		return ssp_pkg::ST_OK;
	endfunction

	function automatic ssp_pkg::response_t predict_response(ssp_pkg::request_t rq);
		ssp_pkg::response_t r;
		int unsigned a, b;
		r = '0;
		a = rq.node_a;
		b = rq.node_b;
		n_cmd[rq.command]++;
		case (rq.command)
			ssp_pkg::CMD_ADD: begin
				if (ssp_pkg::EntryDepth - used < 2) begin
					r.status = ssp_pkg::ST_FULL;
					n_full++;
				end else begin
					link_entry(a, b, rq.weight);
					link_entry(b, a, rq.weight);
				end
			end
			ssp_pkg::CMD_RUN: begin
				r.status = shortest_paths(a);
				if (r.status == ssp_pkg::ST_NO_SOURCE) n_nosrc++;
			end
			ssp_pkg::CMD_QUERY: begin
				if (present[a] && best[a] != DistInf) begin
					r.reachable = 1'b1;
					r.distance = (best[a] > 262143) ? 18'h3FFFF :
						best[a][ssp_pkg::DistW-1:0];
					n_reached++;
					if (back_ok[a]) begin
						r.has_predecessor = 1'b1;
						r.predecessor = back[a][9:0];
					end
				end
			end
			default: wipe_graph();
		endcase
		return r;
	endfunction

	function automatic void queue_item(ssp_pkg::request_t rq);
		pending = {pending, rq};
	endfunction

	// driver: an item is taken when start is high and busy low
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				awaited = {awaited, predict_response(request)};
				void'(pending.pop_front());
			end
			if (start && busy) begin
				start <= 1'b1;
			end else if (pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
				start <= 1'b1;
				request <= pending[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: results cannot be held off, so every done cycle is checked
	always @(posedge clk) begin
		ssp_pkg::response_t want;
		if (arst_n && done) begin
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", response);
			end else begin
				want = awaited.pop_front();
				if (response.status !== want.status || response.reachable !== want.reachable
					|| response.distance !== want.distance
					|| response.predecessor !== want.predecessor
					|| response.has_predecessor !== want.has_predecessor) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", want, response);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CycleLimit) begin
			$display("timeout with %0d results outstanding", awaited.size());
			$display("single_source_shortest_path_unit regression: fail");
			$finish;
		end
	end

	function automatic ssp_pkg::request_t make_item(logic [1:0] c, int a, int b, int w);
		ssp_pkg::request_t rq;
		rq.command = c;
		rq.node_a = 10'(a);
		rq.node_b = 10'(b);
		rq.weight = 8'(w);
		return rq;
	endfunction

	function automatic void fresh_pool();
		int lo;
		lo = $urandom_range(0, 1008);
		for (int i = 0; i < 16; i++)
			pool[i] = ($urandom_range(3) == 0) ? $urandom_range(0, 1023) : lo + i;
		if ($urandom_range(3) == 0) pool[0] = 0;
		if ($urandom_range(3) == 0) pool[1] = 1023;
	endfunction

	function automatic int pick_weight();
		case ($urandom_range(9))
			0: return 0;
			1: return 255;
			2, 3: return $urandom_range(0, 3);
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	// graph building on a small node pool, mixed at random with runs, queries and clears
	function automatic void random_items(int count);
		int k;
		for (int i = 0; i < count; i++) begin
			k = $urandom_range(99);
			if (k < 40)
				queue_item(make_item(ssp_pkg::CMD_ADD, pool[$urandom_range(15)],
					pool[$urandom_range(15)], pick_weight()));
			else if (k < 50)
				queue_item(make_item(ssp_pkg::CMD_RUN, ($urandom_range(7) == 0) ?
					$urandom_range(1023) : pool[$urandom_range(15)], $urandom_range(1023),
					$urandom_range(255)));
			else if (k < 88)
				queue_item(make_item(ssp_pkg::CMD_QUERY, ($urandom_range(7) == 0) ?
					$urandom_range(1023) : pool[$urandom_range(15)], $urandom_range(1023),
					$urandom_range(255)));
			else if (k < 91) begin
				queue_item(make_item(ssp_pkg::CMD_CLEAR, $urandom_range(1023),
					$urandom_range(1023), $urandom_range(255)));
				fresh_pool();
			end else
				queue_item(make_item(2'($urandom_range(2)), $urandom_range(1023),
					$urandom_range(1023), $urandom_range(255)));
		end
	endfunction

	task automatic drain();
		wait (pending.size() == 0 && awaited.size() == 0);
		@(posedge clk);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		queue_item(make_item(ssp_pkg::CMD_QUERY, 0, 0, 0));
		queue_item(make_item(ssp_pkg::CMD_RUN, 3, 0, 0));
		queue_item(make_item(ssp_pkg::CMD_ADD, 0, 1023, 255));
		queue_item(make_item(ssp_pkg::CMD_ADD, 1023, 5, 0));
		queue_item(make_item(ssp_pkg::CMD_ADD, 5, 5, 7));
		queue_item(make_item(ssp_pkg::CMD_ADD, 1, 2, 1));
		queue_item(make_item(ssp_pkg::CMD_ADD, 2, 3, 1));
		queue_item(make_item(ssp_pkg::CMD_ADD, 1, 3, 2));
		queue_item(make_item(ssp_pkg::CMD_RUN, 1, 1023, 255));
		queue_item(make_item(ssp_pkg::CMD_QUERY, 1, 0, 0));
		queue_item(make_item(ssp_pkg::CMD_QUERY, 3, 0, 0));
		queue_item(make_item(ssp_pkg::CMD_QUERY, 1023, 0, 0));
		queue_item(make_item(ssp_pkg::CMD_RUN, 0, 0, 0));
		queue_item(make_item(ssp_pkg::CMD_QUERY, 5, 0, 0));
		queue_item(make_item(ssp_pkg::CMD_QUERY, 1023, 0, 0));
		queue_item(make_item(ssp_pkg::CMD_QUERY, 0, 0, 0));
		queue_item(make_item(ssp_pkg::CMD_RUN, 700, 0, 0));
		queue_item(make_item(ssp_pkg::CMD_QUERY, 1023, 0, 0));
		queue_item(make_item(ssp_pkg::CMD_RUN, 5, 0, 0));
		queue_item(make_item(ssp_pkg::CMD_QUERY, 0, 0, 0));
		queue_item(make_item(ssp_pkg::CMD_CLEAR, 1023, 1023, 255));
		queue_item(make_item(ssp_pkg::CMD_QUERY, 5, 0, 0));
		queue_item(make_item(ssp_pkg::CMD_RUN, 5, 0, 0));
		drain();

		fresh_pool();
		random_items(400);
		drain();

		idle_pct = 80;
		fresh_pool();
		random_items(400);
		drain();

		idle_pct = 0;
		random_items(400);
		drain();

		idle_pct = 24;
		random_items(400);
		drain();

		repeat (50) @(posedge clk);
		$display("covered %0d adds (%0d dropped on a full store), %0d runs (%0d without source)",
			n_cmd[ssp_pkg::CMD_ADD], n_full, n_cmd[ssp_pkg::CMD_RUN], n_nosrc);
		$display("and %0d queries (%0d reached), %0d clears, %0d mismatches",
			n_cmd[ssp_pkg::CMD_QUERY], n_reached, n_cmd[ssp_pkg::CMD_CLEAR], mismatches);
		if (mismatches == 0 && awaited.size() == 0) begin
			$display("single_source_shortest_path_unit regression: pass");
		end else begin
			$display("single_source_shortest_path_unit regression: fail");
		end
		$finish;
	end

endmodule
